### rtl/nbfs_pkg.sv
// Shared types and constants for the nine-bit frame serializer.
package nbfs_pkg;

   localparam int MaxDatagramBytes = 18;
   localparam int MinDatagramBytes = 3;
   localparam int HeaderOffset     = 3;
   localparam int FrameBits        = 11;
   localparam int QueueDepth       = 2;

   localparam int PhaseWidth = 13;
   localparam logic [PhaseWidth-1:0] PhaseStart = 13'd2400;
   localparam logic [PhaseWidth-1:0] PhaseStep  = 13'd1600;
   localparam logic [PhaseWidth-1:0] PhaseMod   = 13'd4800;

   localparam logic [7:0] BitBaseUs = 8'd208;

   localparam logic [1:0] CmdReject = 2'd0;
   localparam logic [1:0] CmdSingle = 2'd1;
   localparam logic [1:0] CmdPair   = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] held_byte;
      logic [7:0] data_byte;
      logic       final_byte;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

### rtl/nbfs_if.sv
// Channel interfaces: input item, result item and configuration write.
interface nbfs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;
   logic [7:0] datagram_length;

   modport source (output valid, data_byte, first_byte, datagram_length, input ready);
   modport sink (input valid, data_byte, first_byte, datagram_length, output ready);
endinterface

interface nbfs_rsp_if;
   logic       valid;
   logic       ready;
   logic       line_level;
   logic [7:0] duration_us;
   logic       last_bit;
   logic       rejected;

   modport source (output valid, line_level, duration_us, last_bit, rejected, input ready);
   modport sink (input valid, line_level, duration_us, last_bit, rejected, output ready);
endinterface

interface nbfs_csr_if;
   logic valid;
   logic ready;
   logic tx_inverted;

   modport source (output valid, tx_inverted, input ready);
   modport sink (input valid, tx_inverted, output ready);
endinterface

### rtl/nbfs_front.sv
// Front end: datagram tracking, length and header checks, command issue.
module nbfs_front #(
   parameter int MAX_DATAGRAM_BYTES = nbfs_pkg::MaxDatagramBytes
) (
   input  logic                       clock,
   input  logic                       reset,
   nbfs_req_if.sink                   req,
   input  nbfs_pkg::queue_status_type q_status,
   output logic                       push,
   output nbfs_pkg::cmd_type          push_cmd
);

   localparam int CountWidth = $clog2(MAX_DATAGRAM_BYTES + 1);
   localparam logic [7:0] MaxLen = 8'(MAX_DATAGRAM_BYTES);
   localparam logic [7:0] MinLen = 8'(nbfs_pkg::MinDatagramBytes);
   localparam logic [7:0] HdrOff = 8'(nbfs_pkg::HeaderOffset);

   logic [7:0]            held_ff, held_in;
   logic [CountWidth-1:0] left_ff, left_in;
   logic [CountWidth-1:0] size_ff, size_in;
   logic                  open_ff, open_in;
   logic                  accept;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      held_in  = held_ff;
      left_in  = left_ff;
      size_in  = size_ff;
      open_in  = open_ff;
      push     = 1'b0;
      push_cmd = '0;
      push_cmd.held_byte = held_ff;
      push_cmd.data_byte = req.data_byte;
      if (accept) begin
         if (req.first_byte) begin
            open_in = 1'b0;
            left_in = '0;
            if (req.datagram_length < MinLen || req.datagram_length > MaxLen) begin
               push          = 1'b1;
               push_cmd.kind = nbfs_pkg::CmdReject;
            end else begin
               size_in = req.datagram_length[CountWidth-1:0];
               held_in = req.data_byte;
               left_in = req.datagram_length[CountWidth-1:0] - CountWidth'(1);
               open_in = 1'b1;
            end
         end else if (!open_ff || left_ff == '0) begin
            open_in = 1'b0;
         end else if (left_ff == size_ff - CountWidth'(1)
                      && 8'(req.data_byte[3:0]) + HdrOff != 8'(size_ff)) begin
            open_in       = 1'b0;
            left_in       = '0;
            push          = 1'b1;
            push_cmd.kind = nbfs_pkg::CmdReject;
         end else begin
            push                = 1'b1;
            push_cmd.kind       = (left_ff == size_ff - CountWidth'(1)) ?
                                  nbfs_pkg::CmdPair : nbfs_pkg::CmdSingle;
            push_cmd.final_byte = (left_ff == CountWidth'(1));
            left_in             = left_ff - CountWidth'(1);
            if (left_ff == CountWidth'(1)) begin
               open_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         left_ff <= '0;
         size_ff <= '0;
         open_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
         left_ff <= left_in;
         size_ff <= size_in;
         open_ff <= open_in;
      end
   end

endmodule

### rtl/nbfs_queue.sv
// Short command queue between front end and bit sequencer.
module nbfs_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  nbfs_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output nbfs_pkg::cmd_type          head,
   output nbfs_pkg::queue_status_type status
);

   localparam int PtrWidth = $clog2(nbfs_pkg::QueueDepth);
   localparam int CntWidth = $clog2(nbfs_pkg::QueueDepth + 1);

   nbfs_pkg::cmd_type     entry_ff [nbfs_pkg::QueueDepth];
   logic [PtrWidth-1:0]   wr_ff, wr_in;
   logic [PtrWidth-1:0]   rd_ff, rd_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign status.full  = (cnt_ff == CntWidth'(nbfs_pkg::QueueDepth));
   assign status.valid = (cnt_ff != '0);
   assign head         = entry_ff[rd_ff];
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PtrWidth'(nbfs_pkg::QueueDepth - 1)) ? '0 : wr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrWidth'(nbfs_pkg::QueueDepth - 1)) ? '0 : rd_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CntWidth'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### rtl/nbfs_back.sv
// Back end: bit sequencer, bit-time accumulator and result register.
module nbfs_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tx_inverted,
   input  nbfs_pkg::cmd_type          head,
   input  nbfs_pkg::queue_status_type q_status,
   output logic                       pop,
   nbfs_rsp_if.source                 rsp
);

   localparam int BitWidth = $clog2(nbfs_pkg::FrameBits);
   localparam logic [BitWidth-1:0] LastBit = BitWidth'(nbfs_pkg::FrameBits - 1);

   nbfs_pkg::cmd_type                 cmd_ff, cmd_in;
   logic                              cmd_valid_ff, cmd_valid_in;
   logic [BitWidth-1:0]               bit_ff, bit_in;
   logic                              half_ff, half_in;
   logic [nbfs_pkg::PhaseWidth-1:0]   phase_ff, phase_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              level_ff, level_in;
   logic [7:0]                        dur_ff, dur_in;
   logic                              last_ff, last_in;
   logic                              rej_ff, rej_in;

   logic                              advance, produce, done, is_pair, is_cmd_byte;
   logic [7:0]                        cur_byte;
   logic [nbfs_pkg::FrameBits-1:0]    frame;
   logic [nbfs_pkg::PhaseWidth-1:0]   phase_base, phase_sum;

   assign advance     = !rsp_valid_ff || rsp.ready;
   assign produce     = advance && cmd_valid_ff;
   assign is_pair     = (cmd_ff.kind == nbfs_pkg::CmdPair);
   assign is_cmd_byte = is_pair && !half_ff;
   assign cur_byte    = is_cmd_byte ? cmd_ff.held_byte : cmd_ff.data_byte;
   assign frame       = {1'b1, is_cmd_byte, cur_byte, 1'b0};
   assign done        = (cmd_ff.kind == nbfs_pkg::CmdReject)
                        || (bit_ff == LastBit && (!is_pair || half_ff));
   assign pop         = q_status.valid && (!cmd_valid_ff || (produce && done));
   assign phase_base  = (is_cmd_byte && bit_ff == '0) ? nbfs_pkg::PhaseStart : phase_ff;
   assign phase_sum   = phase_base + nbfs_pkg::PhaseStep;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.line_level  = level_ff;
   assign rsp.duration_us = dur_ff;
   assign rsp.last_bit    = last_ff;
   assign rsp.rejected    = rej_ff;

   always_comb begin
      cmd_in       = cmd_ff;
      cmd_valid_in = cmd_valid_ff;
      bit_in       = bit_ff;
      half_in      = half_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      level_in     = level_ff;
      dur_in       = dur_ff;
      last_in      = last_ff;
      rej_in       = rej_ff;
      if (advance) begin
         rsp_valid_in = produce;
      end
      if (produce) begin
         if (cmd_ff.kind == nbfs_pkg::CmdReject) begin
            level_in = 1'b0;
            dur_in   = '0;
            last_in  = 1'b1;
            rej_in   = 1'b1;
         end else begin
            level_in = frame[bit_ff] ^ tx_inverted;
            last_in  = cmd_ff.final_byte && done;
            rej_in   = 1'b0;
            if (phase_sum >= nbfs_pkg::PhaseMod) begin
               phase_in = phase_sum - nbfs_pkg::PhaseMod;
               dur_in   = nbfs_pkg::BitBaseUs + 8'd1;
            end else begin
               phase_in = phase_sum;
               dur_in   = nbfs_pkg::BitBaseUs;
            end
         end
         if (done) begin
            bit_in       = '0;
            half_in      = 1'b0;
            cmd_valid_in = 1'b0;
         end else if (bit_ff == LastBit) begin
            bit_in  = '0;
            half_in = 1'b1;
         end else begin
            bit_in = bit_ff + BitWidth'(1);
         end
      end
      if (pop) begin
         cmd_in       = head;
         cmd_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      level_ff <= level_in;
      dur_ff   <= dur_in;
      last_ff  <= last_in;
      rej_ff   <= rej_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         bit_ff       <= '0;
         half_ff      <= 1'b0;
         phase_ff     <= nbfs_pkg::PhaseStart;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         bit_ff       <= bit_in;
         half_ff      <= half_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/nine_bit_frame_serializer.sv
// Top level of the nine-bit frame serializer.
//
//   channel   direction  payload
//   req_bus   in         data_byte, first_byte, datagram_length
//   rsp_bus   out        line_level, duration_us, last_bit, rejected
//   csr_bus   in         tx_inverted
//
// One result leaves per cycle from the bit sequencer: a byte gives 11 bits,
// the second byte of a datagram 22 (it also sends the held first byte), a
// reject one. The front end takes an item per cycle while the two-entry
// command queue has room. Reset is synchronous and clears all control state.
// A stall on rsp_bus holds the result register and backs up into the queue.
module nine_bit_frame_serializer #(
   parameter int MAX_DATAGRAM_BYTES = nbfs_pkg::MaxDatagramBytes
) (
   input  logic        clock,
   input  logic        reset,
   nbfs_req_if.sink    req_bus,
   nbfs_rsp_if.source  rsp_bus,
   nbfs_csr_if.sink    csr_bus
);

   logic                       tx_inverted_ff, tx_inverted_in;
   logic                       push, pop;
   nbfs_pkg::cmd_type          push_cmd, head;
   nbfs_pkg::queue_status_type q_status;

   assign csr_bus.ready  = 1'b1;
   assign tx_inverted_in = (csr_bus.valid && csr_bus.ready) ? csr_bus.tx_inverted
                                                            : tx_inverted_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_inverted_ff <= 1'b0;
      end else begin
         tx_inverted_ff <= tx_inverted_in;
      end
   end

   nbfs_front #(
      .MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .q_status (q_status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   nbfs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   nbfs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .tx_inverted (tx_inverted_ff),
      .head        (head),
      .q_status    (q_status),
      .pop         (pop),
      .rsp         (rsp_bus)
   );

endmodule

### verif/testbench.sv
// Self-checking testbench for the nine-bit frame serializer: datagrams in, line bits out.
`timescale 1ns / 1ps

module testbench;

   localparam int HalfPeriod    = 10;
   localparam int ResetCycles   = 6;
   localparam int SettleCycles  = 40;
   localparam int HoldOffCycles = 300;
   localparam int StallLimit    = 3000;
   localparam int MaxReports    = 10;

   typedef struct packed {
      logic       line_level;
      logic [7:0] duration_us;
      logic       last_bit;
      logic       rejected;
   } line_bit_type;

   class line_bit_scoreboard;
      line_bit_type pending_bits[$];
      bit           inverted;
      bit [7:0]     held_byte;
      bit [4:0]     bytes_due;
      bit [4:0]     frame_size;
      bit [12:0]    phase_acc;
      bit           in_frame;
      int           failures;

      function new();
         phase_acc = nbfs_pkg::PhaseStart;
      endfunction

      function void push_reject();
         pending_bits.push_back('{1'b0, 8'd0, 1'b1, 1'b1});
      endfunction

      function void push_frame(bit [7:0] value, bit command, bit closes);
         bit [10:0]    frame;
         int           acc;
         line_bit_type item;
         frame = {1'b1, command, value, 1'b0};
         for (int i = 0; i < nbfs_pkg::FrameBits; i++) begin
            acc = int'(phase_acc) + int'(nbfs_pkg::PhaseStep);
            item.duration_us = nbfs_pkg::BitBaseUs;
            if (acc >= int'(nbfs_pkg::PhaseMod)) begin
               acc -= int'(nbfs_pkg::PhaseMod);
               item.duration_us = nbfs_pkg::BitBaseUs + 8'd1;
            end
            phase_acc = 13'(acc);
            item.line_level = frame[i] ^ inverted;
            item.last_bit = closes && (i == nbfs_pkg::FrameBits - 1);
            item.rejected = 1'b0;
            pending_bits.push_back(item);
         end
      endfunction

      function void note_byte(bit [7:0] data, bit starts, bit [7:0] length);
         if (starts) begin
            in_frame = 1'b0;
            bytes_due = 5'd0;
            if (length < nbfs_pkg::MinDatagramBytes || length > nbfs_pkg::MaxDatagramBytes) begin
               push_reject();
               return;
            end
            frame_size = length[4:0];
            held_byte = data;
            bytes_due = frame_size - 5'd1;
            phase_acc = nbfs_pkg::PhaseStart;
            in_frame = 1'b1;
            return;
         end
         if (!in_frame || bytes_due == 5'd0) begin
            in_frame = 1'b0;
            return;
         end
         if (bytes_due == frame_size - 5'd1) begin
            if (int'(data[3:0]) + nbfs_pkg::HeaderOffset != int'(frame_size)) begin
               in_frame = 1'b0;
               bytes_due = 5'd0;
               push_reject();
               return;
            end
            push_frame(held_byte, 1'b1, 1'b0);
         end
         bytes_due = bytes_due - 5'd1;
         push_frame(data, 1'b0, bytes_due == 5'd0);
         if (bytes_due == 5'd0) in_frame = 1'b0;
      endfunction

      function void check_bit(bit level, bit [7:0] duration, bit last, bit rejected);
         line_bit_type got;
         line_bit_type want;
         got = '{level, duration, last, rejected};
         if (pending_bits.size() == 0) begin
            if (failures < MaxReports)
               $display("unexpected result: level %0b duration %0d last %0b rejected %0b",
                        got.line_level, got.duration_us, got.last_bit, got.rejected);
            failures++;
            return;
         end
         want = pending_bits.pop_front();
         if (want != got) begin
            if (failures < MaxReports) begin
               $display("mismatch: expected level %0b duration %0d last %0b rejected %0b",
                        want.line_level, want.duration_us, want.last_bit, want.rejected);
               $display("          got      level %0b duration %0d last %0b rejected %0b",
                        got.line_level, got.duration_us, got.last_bit, got.rejected);
            end
            failures++;
         end
      endfunction

      function void close_out();
         if (pending_bits.size() != 0) begin
            if (failures < MaxReports)
               $display("%0d expected results never arrived", pending_bits.size());
            failures += pending_bits.size();
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   idle_on;
   bit   hold_off_request;
   int   counted_items;
   int   stall_count;

   line_bit_scoreboard line_bits = new();

   nbfs_req_if req_bus();
   nbfs_rsp_if rsp_bus();
   nbfs_csr_if csr_bus();

   nine_bit_frame_serializer uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #HalfPeriod clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return nbfs_pkg::MaxDatagramBytes;
      if (r < 70) return $urandom_range(nbfs_pkg::MinDatagramBytes, 8);
      return $urandom_range(nbfs_pkg::MinDatagramBytes, nbfs_pkg::MaxDatagramBytes);
   endfunction

   task automatic send_byte(input logic [7:0] data, input logic starts, input logic [7:0] length);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.data_byte = data;
      req_bus.first_byte = starts;
      req_bus.datagram_length = length;
      do @(posedge clock); while (!req_bus.ready);
      line_bits.note_byte(data, starts, length);
      @(negedge clock);
   endtask

   task automatic send_datagram(input int length, input bit bad_header, input int cut);
      logic [7:0] value;
      int         nibble;
      for (int i = 0; i < cut; i++) begin
         value = 8'($urandom_range(0, 255));
         if (i == 1) begin
            nibble = length - nbfs_pkg::HeaderOffset;
            if (bad_header) nibble = (nibble + $urandom_range(1, 15)) % 16;
            value[3:0] = 4'(nibble);
         end
         send_byte(value, i == 0, (i == 0) ? 8'(length) : 8'($urandom_range(0, 255)));
      end
      counted_items += cut;
   endtask

   task automatic wait_idle();
      req_bus.valid = 1'b0;
      while (line_bits.pending_bits.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_inversion(input bit value);
      wait_idle();
      csr_bus.valid = 1'b1;
      csr_bus.tx_inverted = value;
      do @(posedge clock); while (!csr_bus.ready);
      line_bits.inverted = value;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic run_random(input int quota);
      int goal;
      int pick;
      int length;
      goal = counted_items + quota;
      while (counted_items < goal) begin
         pick = $urandom_range(0, 99);
         length = pick_length();
         if (pick < 66) begin
            send_datagram(length, 1'b0, length);
         end else if (pick < 74) begin
            length = ($urandom_range(0, 1) == 0)
                     ? $urandom_range(0, nbfs_pkg::MinDatagramBytes - 1)
                     : $urandom_range(nbfs_pkg::MaxDatagramBytes + 1, 255);
            send_byte(8'($urandom_range(0, 255)), 1'b1, 8'(length));
            counted_items++;
         end else if (pick < 82) begin
            send_datagram(length, 1'b1, 2);
         end else if (pick < 92) begin
            send_datagram(length, 1'b0, $urandom_range(1, length - 1));
         end else begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)));
            counted_items++;
         end
      end
      length = pick_length();
      send_datagram(length, 1'b0, length);
   endtask

   // hold ready in random stretches; drop it for a long hold-off on request
   initial begin
      int run;
      rsp_bus.ready = 1'b1;
      forever begin
         rsp_bus.ready = 1'b1;
         run = idle_on ? $urandom_range(1, 12) : 1;
         repeat (run) @(negedge clock);
         if (hold_off_request) begin
            rsp_bus.ready = 1'b0;
            repeat (HoldOffCycles) @(negedge clock);
            hold_off_request = 1'b0;
         end else begin
            run = pick_gap();
            if (run > 0) begin
               rsp_bus.ready = 1'b0;
               repeat (run) @(negedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         line_bits.check_bit(rsp_bus.line_level, rsp_bus.duration_us, rsp_bus.last_bit,
                             rsp_bus.rejected);
   end

   initial begin
      stall_count = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready))
            stall_count = 0;
         else
            stall_count++;
         if (stall_count >= StallLimit) begin
            $display("timeout: no item moved for %0d cycles", StallLimit);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      idle_on = 1'b1;
      hold_off_request = 1'b0;
      counted_items = 0;
      req_bus.valid = 1'b0;
      req_bus.data_byte = 8'd0;
      req_bus.first_byte = 1'b0;
      req_bus.datagram_length = 8'd0;
      csr_bus.valid = 1'b0;
      csr_bus.tx_inverted = 1'b0;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_inversion(1'b0);
      // stray item with no datagram open
      send_byte(8'hA5, 1'b0, 8'h00);
      // lengths out of range
      send_byte(8'h00, 1'b1, 8'd0);
      send_byte(8'hFF, 1'b1, 8'hFF);
      send_byte(8'h3C, 1'b1, 8'd2);
      send_byte(8'hC3, 1'b1, 8'd19);
      // shortest datagram
      send_byte(8'h00, 1'b1, 8'd3);
      send_byte(8'hF0, 1'b0, 8'h00);
      send_byte(8'hFF, 1'b0, 8'hFF);
      // header nibble disagrees with length
      send_byte(8'h55, 1'b1, 8'd5);
      send_byte(8'h0F, 1'b0, 8'h00);
      // abandon a longest datagram and restart
      send_byte(8'h11, 1'b1, 8'd18);
      send_byte(8'h0F, 1'b0, 8'h00);
      send_byte(8'h33, 1'b1, 8'd4);
      send_byte(8'h01, 1'b0, 8'h80);
      send_byte(8'hAA, 1'b0, 8'h7F);
      send_byte(8'h7F, 1'b0, 8'h01);
      send_byte(8'hC3, 1'b0, 8'h80);

      write_inversion(1'b1);
      run_random(35);
      write_inversion(1'b0);
      hold_off_request = 1'b1;
      run_random(35);
      idle_on = 1'b0;
      write_inversion(1'b1);
      run_random(35);
      idle_on = 1'b1;
      write_inversion(1'b0);
      run_random(35);

      wait_idle();
      line_bits.close_out();
      if (line_bits.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### filelist.f
rtl/nbfs_pkg.sv
rtl/nbfs_if.sv
rtl/nbfs_front.sv
rtl/nbfs_queue.sv
rtl/nbfs_back.sv
rtl/nine_bit_frame_serializer.sv
verif/testbench.sv
